[src/mat_pkg.sv]
package mat_pkg;

    // Default sizes of the alarm table.
    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;

    // Request kinds carried on the request channel.
    localparam logic [1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [1:0] REQ_CANCEL   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;   // taken and ignored

    // Event kinds carried on the result channel.
    localparam logic [2:0] EVT_SCHEDULED = 3'd0;
    localparam logic [2:0] EVT_FULL      = 3'd1;
    localparam logic [2:0] EVT_CANCELLED = 3'd2;
    localparam logic [2:0] EVT_NOT_FOUND = 3'd3;
    localparam logic [2:0] EVT_FIRED     = 3'd4;
    localparam logic [2:0] EVT_QUIET     = 3'd5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT,
        ST_SCAN
    } mat_state_t;

    // Control from the sequencer to the slot unit at the head of the ring.
    typedef struct packed {
        logic       sweep;    // update pass over all slots
        logic       scan;     // report pass over fired slots
        logic [1:0] req;      // request kind being processed
        logic       claimed;  // a free slot or a cancel match was already taken
        logic       emit;     // the head slot is reported in this cycle
    } mat_ctrl_t;

    // Status from the slot unit back to the sequencer.
    typedef struct packed {
        logic hit;   // head slot was claimed or cancelled
        logic fire;  // head slot fired on this tick
    } mat_stat_t;

endpackage

[src/mat_cell.sv]
module mat_cell
    import mat_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 src_live,
    input  logic                 src_fired,
    input  logic [TIME_BITS-1:0] src_rem,
    input  logic [15:0]          src_ident,
    output logic                 live,
    output logic                 fired,
    output logic [TIME_BITS-1:0] rem,
    output logic [15:0]          ident
);

    logic                 live_reg;
    logic                 fired_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [15:0]          ident_reg;

    // Flags of the slot held in this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= 1'b0;
            fired_reg <= 1'b0;
        end
        else if (shift)
        begin
            live_reg  <= src_live;
            fired_reg <= src_fired;
        end
    end

    // Payload of the slot; only meaningful while the slot is live or fired.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rem_reg   <= src_rem;
            ident_reg <= src_ident;
        end
    end

    assign live  = live_reg;
    assign fired = fired_reg;
    assign rem   = rem_reg;
    assign ident = ident_reg;

endmodule

[src/mat_slot_unit.sv]
module mat_slot_unit
    import mat_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  mat_ctrl_t            ctrl,
    input  logic [15:0]          secs,
    input  logic [15:0]          target,
    input  logic [15:0]          new_id,
    input  logic [TIME_BITS-1:0] best,
    input  logic                 in_live,
    input  logic                 in_fired,
    input  logic [TIME_BITS-1:0] in_rem,
    input  logic [15:0]          in_ident,
    output logic                 out_live,
    output logic                 out_fired,
    output logic [TIME_BITS-1:0] out_rem,
    output logic [15:0]          out_ident,
    output logic [TIME_BITS-1:0] best_next,
    output mat_stat_t            stat
);

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic [CW-1:0]        secs_w;
    logic [CW-1:0]        rem_w;
    logic [CW-1:0]        tmax_w;
    logic [CW-1:0]        diff_w;
    logic [TIME_BITS-1:0] delay_sat;

    // Common-width views of the delay and the remaining time.
    always_comb
    begin
        secs_w    = CW'(secs);
        rem_w     = CW'(in_rem);
        tmax_w    = CW'({TIME_BITS{1'b1}});
        diff_w    = rem_w - secs_w;
        delay_sat = (secs_w > tmax_w) ? {TIME_BITS{1'b1}} : secs_w[TIME_BITS-1:0];
    end

    // Update of the slot passing the head of the ring.
    always_comb
    begin
        out_live  = in_live;
        out_fired = in_fired;
        out_rem   = in_rem;
        out_ident = in_ident;
        stat      = '0;
        if (ctrl.sweep)
        begin
            case (ctrl.req)
                REQ_SCHEDULE:
                begin
                    if (!in_live && !ctrl.claimed)
                    begin
                        out_live  = 1'b1;
                        out_fired = 1'b0;
                        out_rem   = delay_sat;
                        out_ident = new_id;
                        stat.hit  = 1'b1;
                    end
                end
                REQ_CANCEL:
                begin
                    if (in_live && !ctrl.claimed && in_ident == target)
                    begin
                        out_live = 1'b0;
                        stat.hit = 1'b1;
                    end
                end
                REQ_TICK:
                begin
                    if (in_live)
                    begin
                        if (secs_w >= rem_w)
                        begin
                            out_live  = 1'b0;
                            out_fired = 1'b1;
                            out_rem   = '0;
                            stat.fire = 1'b1;
                        end
                        else
                        begin
                            out_rem = diff_w[TIME_BITS-1:0];
                        end
                    end
                end
                default:
                begin
                    out_live = in_live;
                end
            endcase
        end
        else if (ctrl.scan && ctrl.emit)
        begin
            out_fired = 1'b0;
        end
    end

    // Running minimum of the nonzero remaining times after the update.
    always_comb
    begin
        best_next = best;
        if (ctrl.sweep && out_live && out_rem != '0 && (best == '0 || out_rem < best))
        begin
            best_next = out_rem;
        end
    end

endmodule

[src/multi_alarm_timer_table.sv]
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tuser: req_type; tdata: seconds, target_id
// m_*       out        m_tvalid/m_tready   tuser: event_kind; tdata: alarm_id,
//                                          next_remaining; tlast: last
//
// The slots sit in a ring of SLOTS cells that rotates past a single update unit one
// slot per cycle, except while a fired slot waits at the head for a stalled result.
// Every schedule, cancel or tick request costs one full rotation; unknown requests
// are taken and ignored. Schedule, cancel and quiet ticks then load one result once
// the result register is free. A tick that fires alarms instead makes a second
// rotation that reports them.
// Reset clears all live flags and the id counter; no clearing pass is needed.
// A stalled result holds the rotation only while a fired slot waits at the head.
module multi_alarm_timer_table
    import mat_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] seconds, [31:16] target_id
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] alarm_id, [31:16] next_remaining
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast
);

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FC_W  = $clog2(SLOTS + 1);
    localparam int CW    = (TIME_BITS > 16) ? TIME_BITS : 16;

    // Ring of slot cells.
    logic                 c_live  [SLOTS];
    logic                 c_fired [SLOTS];
    logic [TIME_BITS-1:0] c_rem   [SLOTS];
    logic [15:0]          c_ident [SLOTS];

    // Head update unit outputs.
    logic                 h_live;
    logic                 h_fired;
    logic [TIME_BITS-1:0] h_rem;
    logic [15:0]          h_ident;
    logic [TIME_BITS-1:0] best_upd;
    mat_stat_t            stat;
    mat_ctrl_t            ctrl;
    logic                 shift;

    // Sequencer registers.
    mat_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           req_reg, req_next;
    logic [15:0]          secs_reg, secs_next;
    logic [15:0]          target_reg, target_next;
    logic [15:0]          new_id_reg, new_id_next;
    logic [15:0]          id_counter_reg, id_counter_next;
    logic                 done_reg, done_next;
    logic [FC_W-1:0]      fire_cnt_reg, fire_cnt_next;
    logic [TIME_BITS-1:0] best_reg, best_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_kind_reg, out_kind_next;
    logic [15:0]          out_id_reg, out_id_next;
    logic [15:0]          out_rem_reg, out_rem_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 accept;
    logic                 last_step;
    logic [CW-1:0]        best_w;
    logic [15:0]          best_sat;
    logic [15:0]          id_inc;

    genvar gi;

    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            if (gi == SLOTS - 1)
            begin : g_tail
                mat_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .src_live  (h_live),
                    .src_fired (h_fired),
                    .src_rem   (h_rem),
                    .src_ident (h_ident),
                    .live      (c_live[gi]),
                    .fired     (c_fired[gi]),
                    .rem       (c_rem[gi]),
                    .ident     (c_ident[gi])
                );
            end
            else
            begin : g_body
                mat_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (shift),
                    .src_live  (c_live[gi+1]),
                    .src_fired (c_fired[gi+1]),
                    .src_rem   (c_rem[gi+1]),
                    .src_ident (c_ident[gi+1]),
                    .live      (c_live[gi]),
                    .fired     (c_fired[gi]),
                    .rem       (c_rem[gi]),
                    .ident     (c_ident[gi])
                );
            end
        end
    endgenerate

    mat_slot_unit #(.TIME_BITS(TIME_BITS)) u_head (
        .ctrl      (ctrl),
        .secs      (secs_reg),
        .target    (target_reg),
        .new_id    (new_id_reg),
        .best      (best_reg),
        .in_live   (c_live[0]),
        .in_fired  (c_fired[0]),
        .in_rem    (c_rem[0]),
        .in_ident  (c_ident[0]),
        .out_live  (h_live),
        .out_fired (h_fired),
        .out_rem   (h_rem),
        .out_ident (h_ident),
        .best_next (best_upd),
        .stat      (stat)
    );

    // Handshake helpers and the saturated minimum for the result.
    always_comb
    begin
        out_free  = !out_valid_reg || m_tready;
        accept    = s_tvalid && s_tready;
        last_step = (cnt_reg == CNT_W'(SLOTS - 1));
        best_w    = CW'(best_reg);
        best_sat  = (best_w > CW'(16'hFFFF)) ? 16'hFFFF : best_w[15:0];
        id_inc    = id_counter_reg + 16'd1;
    end

    // Next state, head control and result loading.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        req_next        = req_reg;
        secs_next       = secs_reg;
        target_next     = target_reg;
        new_id_next     = new_id_reg;
        id_counter_next = id_counter_reg;
        done_next       = done_reg;
        fire_cnt_next   = fire_cnt_reg;
        best_next       = best_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        s_tready        = 1'b0;
        shift           = 1'b0;
        ctrl            = '0;
        ctrl.req        = req_reg;
        ctrl.claimed    = done_reg;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept && s_tuser != REQ_UNKNOWN)
                begin
                    req_next      = s_tuser;
                    secs_next     = s_tdata[15:0];
                    target_next   = s_tdata[31:16];
                    new_id_next   = (id_inc == 16'd0) ? 16'd1 : id_inc;
                    cnt_next      = '0;
                    done_next     = 1'b0;
                    fire_cnt_next = '0;
                    best_next     = '0;
                    state_next    = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                ctrl.sweep    = 1'b1;
                shift         = 1'b1;
                done_next     = done_reg | stat.hit;
                fire_cnt_next = fire_cnt_reg + FC_W'(stat.fire);
                best_next     = best_upd;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    cnt_next = '0;
                    if (req_reg == REQ_TICK && fire_cnt_next != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rem_next   = best_sat;
                    out_last_next  = 1'b1;
                    case (req_reg)
                        REQ_SCHEDULE:
                        begin
                            out_kind_next = done_reg ? EVT_SCHEDULED : EVT_FULL;
                            out_id_next   = done_reg ? new_id_reg : 16'd0;
                            if (done_reg)
                            begin
                                id_counter_next = new_id_reg;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            out_kind_next = done_reg ? EVT_CANCELLED : EVT_NOT_FOUND;
                            out_id_next   = done_reg ? target_reg : 16'd0;
                        end
                        default:
                        begin
                            out_kind_next = EVT_QUIET;
                            out_id_next   = 16'd0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                ctrl.emit = c_fired[0] && out_free;
                shift     = !c_fired[0] || out_free;
                if (ctrl.emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = EVT_FIRED;
                    out_id_next    = c_ident[0];
                    out_rem_next   = best_sat;
                    out_last_next  = (fire_cnt_reg == FC_W'(1));
                    fire_cnt_next  = fire_cnt_reg - FC_W'(1);
                end
                if (shift)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_step)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            id_counter_reg <= '0;
            done_reg       <= 1'b0;
            fire_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            id_counter_reg <= id_counter_next;
            done_reg       <= done_next;
            fire_cnt_reg   <= fire_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        secs_reg     <= secs_next;
        target_reg   <= target_next;
        new_id_reg   <= new_id_next;
        best_reg     <= best_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_rem_reg  <= out_rem_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rem_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

[src/mat_checker.sv]
module mat_checker
    import mat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A pending result is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A request that does work keeps the block busy in the next cycle.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != REQ_UNKNOWN |=> !s_tready)
        else $error("request taken while the previous one is in progress");

    // Only fired alarms can be followed by further results of the same request.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EVT_FIRED |-> m_tlast)
        else $error("single result without last mark");

    // Failure and quiet results carry no alarm id.
    a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EVT_FULL || m_tuser == EVT_NOT_FOUND ||
                     m_tuser == EVT_QUIET) |-> m_tdata[15:0] == 16'd0)
        else $error("alarm id on a result that has none");

endmodule

bind multi_alarm_timer_table mat_checker u_mat_checker (.*);
